// ----- hdl/byte_ring_buffer_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the byte ring buffer checks.
// ---------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_UNIT_DEFINES_SVH
`define BYTE_RING_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BRB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte ring buffer check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte ring buffer check failed");

`endif

// ----- hdl/brb_pkg.sv -----
// ---------------------------------------------------------------------------
// brb_pkg
// Shared sizes, field layout and operation codes of the byte ring buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  localparam int STORE_DEPTH  = 4096;
  localparam int MAX_READ_RUN = 64;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int RUN_W  = $clog2(MAX_READ_RUN + 1);

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 13;
  localparam int OP_W   = 3;

  // Common width for comparing lengths against counts.
  localparam int CMP_W = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 1;

  localparam int IN_TDATA_W  = ((BYTE_W + LEN_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = OP_W + 1;
  localparam int IN_PAD_W    = IN_TDATA_W - BYTE_W - LEN_W;
  localparam int OUT_TDATA_W = ((BYTE_W + 2 * LEN_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - BYTE_W - 2 * LEN_W;

  // Capacity after reset: 4096 bytes, clamped to the store depth.
  localparam int CAP_RESET = (STORE_DEPTH < 4096) ? STORE_DEPTH : 4096;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_WRITE = 3'd0;
  localparam op_t OP_READ  = 3'd1;
  localparam op_t OP_PEEK  = 3'd2;
  localparam op_t OP_SKIP  = 3'd3;
  localparam op_t OP_CLEAR = 3'd4;

endpackage

`default_nettype wire

// ----- hdl/brb_ram.sv -----
// ---------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/byte_ring_buffer_unit.sv -----
// ---------------------------------------------------------------------------
// byte_ring_buffer_unit
// Circular byte FIFO with all-or-nothing writes, read, peek, skip and clear.
// ---------------------------------------------------------------------------
// The block stores bytes in one 4096-entry byte memory and keeps the read
// position, write position and fill count in registers. Each input
// transaction carries one command. A write, skip, clear or unknown command
// produces exactly one result; the next command is taken in the following
// cycle as long as the output side keeps up. A read or peek of n bytes (n
// up to 64 after saturation; a read is limited to the fill count, a peek
// longer than the fill count is rejected) produces n results, one byte per
// cycle while the output is not stalled, through the single read port of
// the byte memory; no new command is taken until the run is through. A read
// or peek that produces no bytes returns one result, like the simple
// commands. The capacity register is written through the cfg channel, which
// is always ready; a write clamps the value to 1..4096 and empties the
// buffer, so it should only be issued while no command is in flight. The
// byte memory is not cleared after reset: only bytes that were written can
// ever be delivered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_unit import brb_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0 up: write_byte, request_length, zero padding.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0 up: operation, first_of_write.
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,

  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // Fields from bit 0 up: read_data, done_count, fill_level, zero padding.
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // Fields from bit 0 up: status.
  output logic                        out_tuser,
  output logic                        out_tlast,

  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [LEN_W-1:0]       cfg_data
);

  // Controller states: taking commands, or streaming a read or peek run.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // One result as it sits in the output register.
  typedef struct packed {
    logic [LEN_W-1:0]  fill;
    logic [LEN_W-1:0]  done;
    logic [BYTE_W-1:0] data;
    logic              status;
    logic              last;
  } result_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cap_r, cap_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [ADDR_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [ADDR_W-1:0] wr_pos_r, wr_pos_nxt;
  logic [LEN_W-1:0]  wrem_r, wrem_nxt;
  logic              wacc_r, wacc_nxt;
  logic [RUN_W-1:0]  run_n_r, run_n_nxt;
  logic [RUN_W-1:0]  run_cnt_r, run_cnt_nxt;
  logic [ADDR_W-1:0] it_pos_r, it_pos_nxt;
  logic              v1_r, v1_nxt;
  logic              l1_r, l1_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;

  // Fields of the incoming command.
  op_t               op;
  logic              first;
  logic [BYTE_W-1:0] wbyte;
  logic [LEN_W-1:0]  len;

  logic              in_acc;
  logic              cfg_acc;
  logic              s1_adv;
  logic              issue;
  logic              store;
  logic [BYTE_W-1:0] ram_q;

  assign op    = op_t'(in_tuser[OP_W-1:0]);
  assign first = in_tuser[OP_W];
  assign wbyte = in_tdata[BYTE_W-1:0];
  assign len   = in_tdata[BYTE_W +: LEN_W];

  // The stage behind the memory moves into the output register whenever that
  // register is empty or handing over its result in this cycle.
  assign s1_adv = v1_r && (!out_valid_r || out_tready);

  // A new memory read goes out when the memory's output stage is free or is
  // being emptied, so a run streams one byte per cycle under no stall.
  assign issue = (state_r == ST_RUN) && (!v1_r || s1_adv);

  // Commands are taken only when no run byte is still on its way and the
  // single result has a place to go.
  assign in_tready = (state_r == ST_IDLE) && !v1_r && !cfg_valid &&
                     (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;

  always_comb begin
    logic [CMP_W-1:0] len_x, fill_x, cap_x, free_x, n_x, sum_x, cfg_x;
    logic [LEN_W-1:0] e_rem;
    logic             e_acc;
    logic             go;
    logic             start_run;
    result_t          res;

    state_nxt     = state_r;
    cap_nxt       = cap_r;
    fill_nxt      = fill_r;
    rd_pos_nxt    = rd_pos_r;
    wr_pos_nxt    = wr_pos_r;
    wrem_nxt      = wrem_r;
    wacc_nxt      = wacc_r;
    run_n_nxt     = run_n_r;
    run_cnt_nxt   = run_cnt_r;
    it_pos_nxt    = it_pos_r;
    v1_nxt        = v1_r;
    l1_nxt        = l1_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    store         = 1'b0;
    start_run     = 1'b0;

    len_x  = CMP_W'(len);
    fill_x = CMP_W'(fill_r);
    cap_x  = CMP_W'(cap_r);
    free_x = cap_x - fill_x;
    n_x    = '0;
    sum_x  = '0;
    cfg_x  = CMP_W'(cfg_data);
    e_rem  = wrem_r;
    e_acc  = wacc_r;
    go     = 1'b1;
    res    = '{fill: '0, done: '0, data: '0, status: 1'b0, last: 1'b1};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Run byte leaving the memory's output stage.
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '{fill: LEN_W'(fill_r), done: LEN_W'(run_n_r), data: ram_q,
                        status: 1'b0, last: l1_r};
      v1_nxt        = 1'b0;
    end

    // Next read of the run.
    if (issue) begin
      v1_nxt      = 1'b1;
      run_cnt_nxt = RUN_W'(run_cnt_r + 1'b1);
      l1_nxt      = (RUN_W'(run_cnt_r + 1'b1) == run_n_r);
      if (CMP_W'(it_pos_r) + 1'b1 >= cap_x) begin
        it_pos_nxt = '0;
      end else begin
        it_pos_nxt = ADDR_W'(it_pos_r + 1'b1);
      end
      if (RUN_W'(run_cnt_r + 1'b1) == run_n_r) begin
        state_nxt = ST_IDLE;
      end
    end

    if (in_acc) begin
      case (op)
        OP_WRITE: begin
          if (first) begin
            e_rem = len;
            e_acc = 1'b0;
            if (len_x == '0) begin
              wrem_nxt = '0;
              wacc_nxt = 1'b0;
              go       = 1'b0;
            end else if (len_x > free_x) begin
              // Too long for the free space: the rest of the request drops.
              wrem_nxt   = LEN_W'(len - 1'b1);
              wacc_nxt   = 1'b0;
              res.status = 1'b1;
              go         = 1'b0;
            end else begin
              e_acc = 1'b1;
            end
          end
          if (go) begin
            if (e_rem == '0) begin
              // A continuation byte with no open request.
              wrem_nxt   = '0;
              wacc_nxt   = 1'b0;
              res.status = 1'b1;
            end else begin
              wrem_nxt = LEN_W'(e_rem - 1'b1);
              wacc_nxt = e_acc && (LEN_W'(e_rem - 1'b1) != '0);
              if (e_acc && (fill_x < cap_x)) begin
                store    = 1'b1;
                fill_nxt = CNT_W'(fill_r + 1'b1);
                res.done = LEN_W'(1);
                if (CMP_W'(wr_pos_r) + 1'b1 >= cap_x) begin
                  wr_pos_nxt = '0;
                end else begin
                  wr_pos_nxt = ADDR_W'(wr_pos_r + 1'b1);
                end
              end else begin
                res.status = 1'b1;
              end
            end
          end
        end
        OP_READ, OP_PEEK: begin
          n_x = (len_x > CMP_W'(MAX_READ_RUN)) ? CMP_W'(MAX_READ_RUN) : len_x;
          if ((op == OP_PEEK) && (n_x > fill_x)) begin
            res.status = 1'b1;
          end else begin
            if (n_x > fill_x) begin
              n_x = fill_x;
            end
            if (n_x != '0) begin
              start_run   = 1'b1;
              state_nxt   = ST_RUN;
              run_n_nxt   = RUN_W'(n_x);
              run_cnt_nxt = '0;
              it_pos_nxt  = rd_pos_r;
              if (op == OP_READ) begin
                fill_nxt = CNT_W'(fill_x - n_x);
                sum_x    = CMP_W'(rd_pos_r) + n_x;
                if (sum_x >= cap_x) begin
                  sum_x = sum_x - cap_x;
                end
                rd_pos_nxt = ADDR_W'(sum_x);
              end
            end
          end
        end
        OP_SKIP: begin
          if (len_x >= fill_x) begin
            res.done   = LEN_W'(fill_r);
            fill_nxt   = '0;
            rd_pos_nxt = '0;
            wr_pos_nxt = '0;
          end else begin
            res.done = len;
            fill_nxt = CNT_W'(fill_x - len_x);
            sum_x    = CMP_W'(rd_pos_r) + len_x;
            if (sum_x >= cap_x) begin
              sum_x = sum_x - cap_x;
            end
            rd_pos_nxt = ADDR_W'(sum_x);
          end
        end
        OP_CLEAR: begin
          fill_nxt   = '0;
          rd_pos_nxt = '0;
          wr_pos_nxt = '0;
          wrem_nxt   = '0;
          wacc_nxt   = 1'b0;
        end
        default: begin
          res.status = 1'b1;
        end
      endcase

      // Single result, tagged with the fill count left by this command.
      if (!start_run) begin
        res.fill      = LEN_W'(fill_nxt);
        out_valid_nxt = 1'b1;
        out_nxt       = res;
      end
    end

    // A capacity write empties the buffer and cancels any open request.
    if (cfg_acc) begin
      if (cfg_x == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (cfg_x > CMP_W'(STORE_DEPTH)) begin
        cap_nxt = CNT_W'(STORE_DEPTH);
      end else begin
        cap_nxt = CNT_W'(cfg_x);
      end
      fill_nxt   = '0;
      rd_pos_nxt = '0;
      wr_pos_nxt = '0;
      wrem_nxt   = '0;
      wacc_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CNT_W'(CAP_RESET);
      fill_r      <= '0;
      rd_pos_r    <= '0;
      wr_pos_r    <= '0;
      wrem_r      <= '0;
      wacc_r      <= 1'b0;
      run_n_r     <= '0;
      run_cnt_r   <= '0;
      it_pos_r    <= '0;
      v1_r        <= 1'b0;
      l1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      fill_r      <= fill_nxt;
      rd_pos_r    <= rd_pos_nxt;
      wr_pos_r    <= wr_pos_nxt;
      wrem_r      <= wrem_nxt;
      wacc_r      <= wacc_nxt;
      run_n_r     <= run_n_nxt;
      run_cnt_r   <= run_cnt_nxt;
      it_pos_r    <= it_pos_nxt;
      v1_r        <= v1_nxt;
      l1_r        <= l1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result payload needs no reset; out_valid_r qualifies it.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Byte store: writes come from accepted write commands, reads from runs.
  // Both never happen in the same cycle, and a read of an entry always comes
  // in a later cycle than the write of that entry.
  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (wr_pos_r),
    .wr_data (wbyte),
    .rd_en   (issue),
    .rd_addr (it_pos_r),
    .rd_data (ram_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_r.fill, out_r.done, out_r.data};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;

endmodule

`default_nettype wire

// ----- hdl/brb_checker.sv -----
// ---------------------------------------------------------------------------
// brb_checker
// Port-level checks of the byte ring buffer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "byte_ring_buffer_unit_defines.svh"

module brb_checker import brb_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TUSER_W-1:0]  in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser,
  input wire logic                   out_tlast
);

  // A stalled result stays offered.
  `BRB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // A write byte answers with its single result in the next cycle.
  `BRB_ASSERT_NEXT(a_write_result,
    in_tvalid && in_tready && (in_tuser[OP_W-1:0] == OP_WRITE),
    out_tvalid && out_tlast)

  // A rejected command moves no byte and delivers no data.
  `BRB_ASSERT_SAME(a_reject_empty, out_tvalid && out_tuser,
    out_tdata[BYTE_W+LEN_W-1:0] == '0)

  // Only read and peek runs emit several results, and they always move bytes.
  `BRB_ASSERT_SAME(a_run_count, out_tvalid && !out_tlast,
    (out_tdata[BYTE_W +: LEN_W] != '0) && !out_tuser)

endmodule

bind byte_ring_buffer_unit brb_checker u_brb_checker (.*);

`default_nettype wire
